/* src/lfsa_pkg.sv */
// Package: sizes, codes and shared types of the lowest-free slot allocator.
`default_nettype none
package lfsa_pkg;

    localparam int SLOT_COUNT = 64;
    localparam int SLOT_W     = 6;
    localparam int STATUS_W   = 2;
    localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int EXT_W      = (IDX_W + 1 > SLOT_W) ? IDX_W + 1 : SLOT_W;

    // Lowest-free search runs in groups of eight slots.
    localparam int GRP_W   = 8;
    localparam int GRP_IW  = 3;
    localparam int NGRP    = (SLOT_COUNT + GRP_W - 1) / GRP_W;
    localparam int GSEL_W  = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int PAD_N   = NGRP * GRP_W;

    typedef enum logic {
        KIND_ALLOC   = 1'b0,
        KIND_RELEASE = 1'b1
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOT_OPEN = 2'd2
    } t_status;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
    } t_free_info;

endpackage
`default_nettype wire

/* src/lfsa_if.sv */
// Interfaces: request and response channels of the slot allocator.
`default_nettype none
interface lfsa_req_if
    import lfsa_pkg::*;
    ;
    logic              valid;
    logic              ready;
    logic              kind;
    logic [SLOT_W-1:0] slot;
    logic              still_referenced;

    modport source (output valid, output kind, output slot, output still_referenced,
                    input ready);
    modport sink   (input valid, input kind, input slot, input still_referenced,
                    output ready);
endinterface

interface lfsa_rsp_if
    import lfsa_pkg::*;
    ;
    logic                valid;
    logic                ready;
    logic [SLOT_W-1:0]   granted_slot;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output granted_slot, output status, input ready);
    modport sink   (input valid, input granted_slot, input status, output ready);
endinterface
`default_nettype wire

/* src/lowest_free_slot_allocator.sv */
// Lowest-free slot allocator: input register, decision logic, result register.
// Throughput: one transaction per cycle while the sink takes each
// response, limited by the combinational lowest-free priority
// encode over the occupancy map.
// Reset (synchronous, active low): all slots free, both stages empty.
`default_nettype none
module lowest_free_slot_allocator
    import lfsa_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lfsa_req_if.sink   i_req,
    lfsa_rsp_if.source o_rsp
);

    logic                r_s1_valid;
    logic                r_kind;
    logic [SLOT_W-1:0]   r_slot;
    logic                r_keep;
    logic                r_out_valid;
    logic [SLOT_W-1:0]   r_granted;
    t_status             r_status;

    logic                w_advance;
    logic                w_fire;
    logic                w_accept;
    logic [SLOT_W-1:0]   w_granted;
    t_status             w_status;

    assign w_advance   = !r_out_valid || o_rsp.ready;
    assign w_fire      = r_s1_valid && w_advance;
    assign i_req.ready = !r_s1_valid || w_advance;
    assign w_accept    = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= i_req.kind;
            r_slot <= i_req.slot;
            r_keep <= i_req.still_referenced;
        end
    end

    lfsa_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (w_fire),
        .i_kind    (r_kind),
        .i_slot    (r_slot),
        .i_keep    (r_keep),
        .o_granted (w_granted),
        .o_status  (w_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // hold result while the sink stalls
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_granted <= w_granted;
            r_status  <= w_status;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.granted_slot = r_granted;
    assign o_rsp.status       = r_status;

    // Two grants in a row never hand out the same slot.
    a_no_double_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && t_kind'(r_kind) == KIND_ALLOC && w_status == ST_OK)
        |=> !(w_fire && t_kind'(r_kind) == KIND_ALLOC && w_status == ST_OK
              && w_granted == $past(w_granted)))
        else $error("same slot granted twice in a row");

    // Status codes match the request kind; releases never grant a slot.
    a_status_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |-> ((t_kind'(r_kind) == KIND_ALLOC) ? (w_status != ST_NOT_OPEN)
                    : (w_status != ST_FULL && w_granted == '0)))
        else $error("status does not fit request kind");

    // A pending request is not dropped while the output stalls.
    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_advance) |=> r_s1_valid)
        else $error("pending request lost during stall");

endmodule
`default_nettype wire

/* src/lfsa_encoder.sv */
// Two-level priority encoder: lowest free slot of the occupancy map.
`default_nettype none
module lfsa_encoder
    import lfsa_pkg::*;
(
    input  wire logic [SLOT_COUNT-1:0] i_map,
    output t_free_info                 o_free
);

    logic [PAD_N-1:0]       w_free;
    logic [NGRP-1:0]        w_grp_any;
    logic [GRP_IW-1:0]      w_grp_low [NGRP];
    logic [GSEL_W-1:0]      w_sel;

    // Padding slots beyond the table never count as free.
    assign w_free = PAD_N'(~i_map);

    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            w_grp_any[g] = |w_free[g*GRP_W +: GRP_W];
            w_grp_low[g] = '0;
            for (int b = GRP_W - 1; b >= 0; b--) begin
                if (w_free[g*GRP_W + b]) begin
                    w_grp_low[g] = GRP_IW'(b);
                end
            end
        end
    end

    always_comb begin
        w_sel = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (w_grp_any[g]) begin
                w_sel = GSEL_W'(g);
            end
        end
    end

    assign o_free.found = |w_grp_any;
    assign o_free.idx   = IDX_W'({w_sel, w_grp_low[w_sel]});

endmodule
`default_nettype wire

/* src/lfsa_core.sv */
// Occupancy map and the allocate / release decision for one transaction.
`default_nettype none
module lfsa_core
    import lfsa_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_fire,
    input  wire logic                i_kind,
    input  wire logic [SLOT_W-1:0]   i_slot,
    input  wire logic                i_keep,
    output logic      [SLOT_W-1:0]   o_granted,
    output t_status                  o_status
);

    logic [SLOT_COUNT-1:0] r_map;
    logic [SLOT_COUNT-1:0] n_map;
    t_free_info            w_free;
    logic [EXT_W-1:0]      w_slot_ext;
    logic                  w_in_range;
    logic [IDX_W-1:0]      w_rel_idx;
    logic                  w_rel_open;

    // Every slot below the lowest free one is occupied, so the search
    // pointer is the encoder result itself.
    lfsa_encoder u_enc (
        .i_map  (r_map),
        .o_free (w_free)
    );

    assign w_slot_ext = EXT_W'(i_slot);
    assign w_in_range = w_slot_ext < EXT_W'(SLOT_COUNT);
    assign w_rel_idx  = w_slot_ext[IDX_W-1:0];
    assign w_rel_open = w_in_range && r_map[w_rel_idx];

    always_comb begin
        n_map     = r_map;
        o_granted = '0;
        o_status  = ST_OK;
        if (t_kind'(i_kind) == KIND_ALLOC) begin
            if (w_free.found) begin
                o_granted          = SLOT_W'(w_free.idx);
                n_map[w_free.idx]  = 1'b1;
            end else begin
                o_status = ST_FULL;
            end
        end else begin
            if (!w_rel_open) begin
                o_status = ST_NOT_OPEN;
            end else if (!i_keep) begin
                n_map[w_rel_idx] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map <= '0;
        end else if (i_fire) begin
            r_map <= n_map;
        end
    end

endmodule
`default_nettype wire
